FILE: rtl/pca_pkg.sv
`default_nettype none

package pca_pkg;

	localparam int MAX_COLUMNS_DEF = 32;

	localparam int COL_W      = 5;
	localparam int VAL_W      = 64;
	localparam int MODE_W     = 2;
	localparam int COUNT_W    = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'd1;

	// aggregation modes; the unused code behaves as keep first
	localparam logic [MODE_W-1:0] MODE_SUM   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LAST  = 2'd2;

	typedef struct packed {
		logic                    key_found;
		logic [COL_W-1:0]        column;
		logic signed [VAL_W-1:0] value;
		logic                    value_null;
		logic                    partition_end;
	} row_t;

	typedef struct packed {
		logic [COL_W-1:0]        out_column;
		logic signed [VAL_W-1:0] out_value;
		logic                    out_null;
		logic                    out_last;
	} res_t;

	// one accumulator entry as stored in memory
	typedef struct packed {
		logic             is_null;
		logic [VAL_W-1:0] acc;
	} acc_entry_t;

	// flush sequencer status toward the rest of the core
	typedef struct packed {
		logic issue;
		logic clear_seen;
		logic busy;
	} flush_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/pivot_column_aggregator_core.sv
`default_nettype none

// A row folds into its column in the cycle after acceptance; a partition's first result
// follows its end row through the fold, flush state, memory read and output registers, then
// one per cycle unless stalled. One row per cycle unless stalled; an end row stalls rows
// while the flush reads all columns over the single memory read port (a zero count only
// while pending). Reset: asynchronous, active low; mode to sum, column_count to 1, all
// columns unseen (null, zero); memory contents are not cleared, only masked by seen flags.
module pivot_column_aggregator_core #(
	parameter int MAX_COLUMNS = pca_pkg::MAX_COLUMNS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [pca_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pca_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             row_valid,
	output      logic                             row_stall,
	input  wire pca_pkg::row_t                    row,
	output      logic                             res_valid,
	input  wire logic                             res_stall,
	output      pca_pkg::res_t                    res
);
	import pca_pkg::*;

	localparam int IDXW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int CNTW = $clog2(MAX_COLUMNS + 1);
	localparam int CMPW = 7;

	logic [MODE_W-1:0]       mode_q;
	logic [COUNT_W-1:0]      count_q;
	logic [CNTW-1:0]         count_eff;

	logic                    row_acc;
	logic                    rd_en;
	logic [IDXW-1:0]         rd_addr;
	logic [IDXW-1:0]         flush_addr;
	acc_entry_t              rd_data;
	logic                    wr_en;
	logic [IDXW-1:0]         wr_addr;
	acc_entry_t              wr_data;
	logic [MAX_COLUMNS-1:0]  seen;
	logic                    end_pending;
	flush_ctl_t              fctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SUM;
			count_q <= COUNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:  mode_q  <= cfg_data[MODE_W-1:0];
				REG_COUNT: count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign count_eff = (CMPW'(count_q) > CMPW'(MAX_COLUMNS)) ? CNTW'(MAX_COLUMNS)
	                                                        : CNTW'(count_q);

	// hold rows while an end row waits to flush or the flush still uses the read port
	assign row_stall = end_pending || fctl.busy;
	assign row_acc   = row_valid && !row_stall;

	assign rd_en   = row_acc || fctl.issue;
	assign rd_addr = row_acc ? IDXW'(row.column) : flush_addr;

	pca_acc_mem #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pca_row_fold #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_fold (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (row_acc),
		.row         (row),
		.mode        (mode_q),
		.count       (count_eff),
		.rd_data     (rd_data),
		.clear_seen  (fctl.clear_seen),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.seen        (seen),
		.end_pending (end_pending)
	);

	pca_flush #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_flush (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (end_pending),
		.count     (count_eff),
		.seen      (seen),
		.rd_data   (rd_data),
		.ctl       (fctl),
		.rd_addr   (flush_addr),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(row_acc && fctl.issue))
		else $error("row read and flush read collide on the memory port");

	a_end_blocks_rows: assert property (@(posedge clk) disable iff (!arst_n)
		(end_pending && (count_eff != '0)) |=> !row_acc)
		else $error("row accepted before the partition flush finished");

	a_clear_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		fctl.clear_seen |-> !wr_en)
		else $error("row write lands while the seen marks are cleared");

endmodule

`default_nettype wire

FILE: rtl/pca_acc_mem.sv
`default_nettype none

module pca_acc_mem #(
	parameter int MAX_COLUMNS = pca_pkg::MAX_COLUMNS_DEF,
	localparam int IDXW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [IDXW-1:0]      wr_addr,
	input  wire pca_pkg::acc_entry_t  wr_data,
	input  wire logic                 rd_en,
	input  wire logic [IDXW-1:0]      rd_addr,
	output      pca_pkg::acc_entry_t  rd_data
);
	import pca_pkg::*;

	acc_entry_t mem [MAX_COLUMNS];
	acc_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold read data while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

FILE: rtl/pca_row_fold.sv
`default_nettype none

module pca_row_fold #(
	parameter int MAX_COLUMNS = pca_pkg::MAX_COLUMNS_DEF,
	localparam int IDXW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
	localparam int CNTW = $clog2(MAX_COLUMNS + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire pca_pkg::row_t                row,
	input  wire logic [pca_pkg::MODE_W-1:0]   mode,
	input  wire logic [CNTW-1:0]              count,
	input  wire pca_pkg::acc_entry_t          rd_data,
	input  wire logic                         clear_seen,
	output      logic                         wr_en,
	output      logic [IDXW-1:0]              wr_addr,
	output      pca_pkg::acc_entry_t          wr_data,
	output      logic [MAX_COLUMNS-1:0]       seen,
	output      logic                         end_pending
);
	import pca_pkg::*;

	localparam int CMPW = 7;

	logic                    valid_s1;
	logic                    hit_s1;
	logic                    end_s1;
	logic [IDXW-1:0]         idx_s1;
	logic [VAL_W-1:0]        value_s1;
	logic                    null_s1;

	logic                    fwd_valid_q;
	logic [IDXW-1:0]         fwd_addr_q;
	acc_entry_t              fwd_data_q;

	logic [MAX_COLUMNS-1:0]  seen_q;

	logic                    hit;
	logic                    cur_seen;
	acc_entry_t              cur;
	acc_entry_t              nxt;

	assign hit = row.key_found && (CMPW'(row.column) < CMPW'(count));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1   <= hit;
			end_s1   <= row.partition_end;
			idx_s1   <= IDXW'(row.column);
			value_s1 <= row.value;
			null_s1  <= row.value_null;
		end
	end

	// the write of the previous cycle lands at the same edge as this row's read
	always_comb begin
		cur_seen = seen_q[idx_s1];
		if (!cur_seen) begin
			cur.is_null = 1'b1;
			cur.acc     = '0;
		end else if (fwd_valid_q && (fwd_addr_q == idx_s1)) begin
			cur = fwd_data_q;
		end else begin
			cur = rd_data;
		end
	end

	always_comb begin
		nxt = cur;
		if (!cur_seen || (mode == MODE_LAST)) begin
			nxt.is_null = null_s1;
			nxt.acc     = null_s1 ? '0 : value_s1;
		end else if (mode == MODE_SUM) begin
			if (!null_s1) begin
				nxt.is_null = 1'b0;
				nxt.acc     = cur.is_null ? value_s1 : (cur.acc + value_s1);
			end
		end
	end

	assign wr_en   = valid_s1 && hit_s1;
	assign wr_addr = idx_s1;
	assign wr_data = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= wr_addr;
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (clear_seen) begin
			seen_q <= '0;
		end else if (wr_en) begin
			seen_q[wr_addr] <= 1'b1;
		end
	end

	assign seen        = seen_q;
	assign end_pending = valid_s1 && end_s1;

endmodule

`default_nettype wire

FILE: rtl/pca_flush.sv
`default_nettype none

module pca_flush #(
	parameter int MAX_COLUMNS = pca_pkg::MAX_COLUMNS_DEF,
	localparam int IDXW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
	localparam int CNTW = $clog2(MAX_COLUMNS + 1)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [CNTW-1:0]         count,
	input  wire logic [MAX_COLUMNS-1:0]  seen,
	input  wire pca_pkg::acc_entry_t     rd_data,
	output      pca_pkg::flush_ctl_t     ctl,
	output      logic [IDXW-1:0]         rd_addr,
	output      logic                    res_valid,
	input  wire logic                    res_stall,
	output      pca_pkg::res_t           res
);
	import pca_pkg::*;

	typedef enum logic [1:0] {
		FL_IDLE = 2'b01,
		FL_RUN  = 2'b10
	} fl_state_t;

	fl_state_t        state_q, state_d;
	logic [CNTW-1:0]  k_q;
	logic             valid_s1;
	logic [CNTW-1:0]  k_s1;
	logic             last_s1;
	logic             seen_s1;
	logic             res_valid_q;
	res_t             res_q;

	logic             out_ready;
	logic             issue;
	logic             is_last;
	logic             col_null;

	assign out_ready = !res_valid_q || !res_stall;
	assign issue     = (state_q == FL_RUN) && (!valid_s1 || out_ready);
	assign is_last   = (k_q + CNTW'(1)) == count;

	always_comb begin
		state_d = state_q;
		case (state_q)
			FL_IDLE: begin
				if (start && (count != '0)) begin
					state_d = FL_RUN;
				end
			end
			FL_RUN: begin
				if (issue && is_last) begin
					state_d = FL_IDLE;
				end
			end
			default: state_d = FL_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FL_IDLE;
			k_q         <= '0;
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + CNTW'(1);
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (out_ready) begin
				valid_s1 <= 1'b0;
			end
			if (out_ready) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			k_s1    <= k_q;
			last_s1 <= is_last;
			seen_s1 <= seen[k_q[IDXW-1:0]];
		end
	end

	assign col_null = !seen_s1 || rd_data.is_null;

	always_ff @(posedge clk) begin
		if (out_ready && valid_s1) begin
			res_q.out_column <= COL_W'(k_s1);
			res_q.out_value  <= col_null ? '0 : rd_data.acc;
			res_q.out_null   <= col_null;
			res_q.out_last   <= last_s1;
		end
	end

	assign rd_addr        = k_q[IDXW-1:0];
	assign ctl.issue      = issue;
	// drop all seen marks once the last column is read, or at once for an empty run
	assign ctl.clear_seen = (issue && is_last) || (start && (count == '0));
	assign ctl.busy       = (state_q == FL_RUN) || valid_s1;
	assign res_valid      = res_valid_q;
	assign res            = res_q;

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FL_RUN) |-> (k_q < count))
		else $error("flush index ran past the column count");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_ready) |=> (valid_s1 && $stable(k_s1)))
		else $error("pending column lost under output stall");

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == FL_IDLE) && !valid_s1)
		else $error("flush started while a previous flush is active");

endmodule

`default_nettype wire
